FILE: rtl/rcgn_pkg.sv
// ---------------------------------------------------------------------------
// rcgn_pkg: shared types and constants for the crown gesture normalizer
// Result codes, work queue entry, back-end states and fixed-point constants.
// ---------------------------------------------------------------------------
package rcgn_pkg;

  // Result codes on the action output
  typedef enum logic [1:0] {
    ACT_BEGIN  = 2'd0,
    ACT_UPDATE = 2'd1,
    ACT_END    = 2'd2,
    ACT_ERROR  = 2'd3
  } action_t;

  // Input opcodes
  localparam logic OP_AXIS = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Work classes handed from front to back
  typedef enum logic [2:0] {
    CMD_BEGIN,
    CMD_UPDATE,
    CMD_ZERO,
    CMD_END,
    CMD_ERROR
  } cmd_t;

  // Back-end sequencer states
  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MUL1,
    BK_MUL2,
    BK_DIV,
    BK_FIN
  } back_state_t;

  localparam int TS_W      = 64;
  localparam int SCROLL_W  = 16;
  localparam int SMAG_W    = 16;   // magnitude of a 16-bit signed value, up to 32768
  localparam int TICK_W    = 16;
  localparam int DEG_W     = 24;
  localparam int VEL_W     = 32;

  localparam logic [TICK_W-1:0] TIMEOUT_RESET = 16'd100;

  // degrees * 256 = smag * 360 * 256 / 532 = smag * 23040 / 133
  localparam logic [14:0] DEG_SCALE  = 15'd23040;
  localparam logic [7:0]  DEG_DEN    = 8'd133;
  localparam logic [19:0] US_PER_S   = 20'd1000000;

  localparam int P1_W      = 30;   // smag * 23040
  localparam int P2_W      = 50;   // smag * 23040 * 1e6
  localparam int DEN_W     = 72;   // interval * 133
  localparam int DEG_MAG_W = 23;

  // floor(x / 133) = (x * ceil(2^38 / 133)) >> 38 for x < 2^30
  localparam logic [30:0] DEG_RECIP       = 31'd2066751181;
  localparam int          DEG_RECIP_SHIFT = 38;
  localparam int          PROD_W          = 61;

  localparam int DIV_CNT_W = $clog2(P2_W);

  // Queue entry between front and back
  typedef struct packed {
    cmd_t              cmd;
    logic              neg;
    logic [SMAG_W-1:0] smag;
    logic [TS_W-1:0]   interval;
  } work_t;

  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

endpackage

FILE: rtl/rcgn_front.sv
// ---------------------------------------------------------------------------
// rcgn_front: item intake and session tracking
// Accepts items, keeps the session, timestamp and timeout state, and pushes
// one work entry for every item that produces a result.
// ---------------------------------------------------------------------------
module rcgn_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         opcode,
  input  logic                         from_wheel,
  input  logic [rcgn_pkg::TS_W-1:0]    timestamp_us,
  input  logic [rcgn_pkg::SCROLL_W-1:0] scroll_v120,
  input  logic                         cfg_valid,
  input  logic [rcgn_pkg::TICK_W-1:0]  cfg_data,
  input  logic                         q_full,
  output logic                         push,
  output rcgn_pkg::work_t              push_item
);
  import rcgn_pkg::*;

  logic              accept;
  logic              session_active, session_active_next;
  logic [TS_W-1:0]   previous_time, previous_time_next;
  logic [TICK_W-1:0] ticks_remaining, ticks_remaining_next;
  logic [TICK_W-1:0] idle_timeout_ticks;
  logic              neg;
  logic [SMAG_W-1:0] smag;
  logic [TS_W-1:0]   interval;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // sign and magnitude of the scroll value
  assign neg      = scroll_v120[SCROLL_W-1];
  assign smag     = neg ? SMAG_W'(-scroll_v120) : SMAG_W'(scroll_v120);
  assign interval = timestamp_us - previous_time;

  // classify the item and update session state
  always_comb begin
    session_active_next  = session_active;
    previous_time_next   = previous_time;
    ticks_remaining_next = ticks_remaining;
    push                 = 1'b0;
    push_item.cmd        = CMD_ERROR;
    push_item.neg        = neg;
    push_item.smag       = smag;
    push_item.interval   = interval;
    if (accept) begin
      if (opcode == OP_TICK) begin
        if (session_active) begin
          if (ticks_remaining <= TICK_W'(1)) begin
            ticks_remaining_next = '0;
            session_active_next  = 1'b0;
            previous_time_next   = '0;
            push                 = 1'b1;
            push_item.cmd        = CMD_END;
          end else begin
            ticks_remaining_next = ticks_remaining - TICK_W'(1);
          end
        end
      end else if (!from_wheel) begin
        push          = 1'b1;
        push_item.cmd = CMD_ERROR;
      end else begin
        push                 = 1'b1;
        ticks_remaining_next = idle_timeout_ticks;
        previous_time_next   = timestamp_us;
        if (!session_active) begin
          session_active_next = 1'b1;
          push_item.cmd       = CMD_BEGIN;
        end else if (interval == '0) begin
          push_item.cmd = CMD_ZERO;
        end else begin
          push_item.cmd = CMD_UPDATE;
        end
      end
    end
  end

  // state and timeout register
  always_ff @(posedge clk) begin
    if (rst) begin
      session_active     <= 1'b0;
      previous_time      <= '0;
      ticks_remaining    <= '0;
      idle_timeout_ticks <= TIMEOUT_RESET;
    end else begin
      session_active  <= session_active_next;
      previous_time   <= previous_time_next;
      ticks_remaining <= ticks_remaining_next;
      if (cfg_valid) begin
        idle_timeout_ticks <= cfg_data;
      end
    end
  end

endmodule

FILE: rtl/rcgn_queue.sv
// ---------------------------------------------------------------------------
// rcgn_queue: work queue between front and back
// Small register FIFO; the back end pops in order.
// ---------------------------------------------------------------------------
module rcgn_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  rcgn_pkg::work_t push_item,
  output logic            full,
  input  logic            pop,
  output logic            q_valid,
  output rcgn_pkg::work_t q_item
);
  import rcgn_pkg::*;

  work_t                 entries [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr;
  logic [FIFO_PTR_W-1:0] rd_ptr;
  logic [FIFO_CNT_W-1:0] count;
  logic                  do_push;
  logic                  do_pop;

  assign full    = (count == FIFO_CNT_W'(FIFO_DEPTH));
  assign q_valid = (count != '0);
  assign q_item  = entries[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && q_valid;

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr + FIFO_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr + FIFO_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + FIFO_CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - FIFO_CNT_W'(1);
      end
    end
  end

endmodule

FILE: rtl/rcgn_back.sv
// ---------------------------------------------------------------------------
// rcgn_back: degree and velocity datapath
// Pops work entries, scales the scroll value to Q.8 degrees, runs a
// bit-serial divide for the velocity and holds the result in an output
// register.
// ---------------------------------------------------------------------------
module rcgn_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       q_valid,
  input  rcgn_pkg::work_t            q_item,
  output logic                       pop,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [1:0]                 action,
  output logic [rcgn_pkg::DEG_W-1:0] degree_q8,
  output logic [rcgn_pkg::VEL_W-1:0] velocity_q8
);
  import rcgn_pkg::*;

  back_state_t          state, state_next;
  work_t                cur;
  logic [P1_W-1:0]      p1;
  logic [DEN_W-1:0]     den;
  logic [DEG_MAG_W-1:0] deg_mag;
  logic [P2_W-1:0]      quo;
  logic [P2_W-1:0]      rem;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 slot_free;
  logic                 out_load;
  logic                 compute;

  logic [P2_W:0]        trial;
  logic                 ge;
  logic [P2_W-1:0]      lim;
  logic [VEL_W-1:0]     mag32;
  logic [VEL_W-1:0]     vel_val;
  logic [DEG_W-1:0]     deg_val;
  action_t              act_val;
  logic [DEG_W-1:0]     deg_load;
  logic [VEL_W-1:0]     vel_load;

  assign slot_free = !out_valid || out_ready;
  assign compute   = (q_item.cmd == CMD_BEGIN) || (q_item.cmd == CMD_UPDATE);

  // one divide step
  assign trial = {rem, quo[P2_W-1]};
  assign ge    = ({{(DEN_W - P2_W - 1){1'b0}}, trial} >= den);

  // velocity saturation and sign
  assign lim     = cur.neg ? P2_W'(64'h8000_0000) : P2_W'(64'h7FFF_FFFF);
  assign mag32   = (quo > lim) ? lim[VEL_W-1:0] : quo[VEL_W-1:0];
  assign vel_val = cur.neg ? VEL_W'(-mag32) : mag32;
  assign deg_val = cur.neg ? DEG_W'(-{1'b0, deg_mag}) : DEG_W'({1'b0, deg_mag});

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    out_load   = 1'b0;
    act_val    = ACT_ERROR;
    deg_load   = '0;
    vel_load   = '0;
    unique case (state)
      BK_IDLE: begin
        if (q_valid) begin
          if (compute) begin
            pop        = 1'b1;
            state_next = BK_MUL1;
          end else if (slot_free) begin
            pop      = 1'b1;
            out_load = 1'b1;
            case (q_item.cmd)
              CMD_ZERO: act_val = ACT_UPDATE;
              CMD_END:  act_val = ACT_END;
              default:  act_val = ACT_ERROR;
            endcase
          end
        end
      end
      BK_MUL1: state_next = BK_MUL2;
      BK_MUL2: state_next = (cur.cmd == CMD_UPDATE) ? BK_DIV : BK_FIN;
      BK_DIV: begin
        if (cnt == '0) begin
          state_next = BK_FIN;
        end
      end
      BK_FIN: begin
        deg_load = deg_val;
        if (cur.cmd == CMD_BEGIN) begin
          act_val  = ACT_BEGIN;
          vel_load = '0;
        end else begin
          act_val  = ACT_UPDATE;
          vel_load = vel_val;
        end
        if (slot_free) begin
          out_load   = 1'b1;
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  // datapath
  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= q_item;
    end
    unique case (state)
      BK_MUL1: begin
        p1  <= P1_W'(P1_W'(cur.smag) * P1_W'(DEG_SCALE));
        den <= DEN_W'(DEN_W'(cur.interval) * DEN_W'(DEG_DEN));
      end
      BK_MUL2: begin
        deg_mag <= DEG_MAG_W'((PROD_W'(p1) * PROD_W'(DEG_RECIP)) >> DEG_RECIP_SHIFT);
        quo     <= P2_W'(P2_W'(p1) * P2_W'(US_PER_S));
        rem     <= '0;
        cnt     <= DIV_CNT_W'(P2_W - 1);
      end
      BK_DIV: begin
        rem <= ge ? P2_W'(trial - den[P2_W:0]) : trial[P2_W-1:0];
        quo <= {quo[P2_W-2:0], ge};
        cnt <= cnt - DIV_CNT_W'(1);
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      action      <= 2'(act_val);
      degree_q8   <= deg_load;
      velocity_q8 <= vel_load;
    end
  end

endmodule

FILE: rtl/rotary_crown_gesture_normalizer.sv
// ---------------------------------------------------------------------------
// rotary_crown_gesture_normalizer: crown rotate session builder
// Wheel events and millisecond ticks in, begin/update/end/error items out.
// ---------------------------------------------------------------------------
// The front end takes one item per cycle while its two-entry work queue has
// room; ticks that end nothing produce no result. A begin passes the back
// end's multiply states and finish state; end, error and zero-interval
// update load the output from idle; a nonzero-interval update adds the
// 50-step bit-serial divide of the scaled value by interval * 133. A result
// waits in the output register, not blocking intake until the queue fills.
module rotary_crown_gesture_normalizer (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         opcode,
  input  logic                         from_wheel,
  input  logic [rcgn_pkg::TS_W-1:0]    timestamp_us,
  input  logic [rcgn_pkg::SCROLL_W-1:0] scroll_v120,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [1:0]                   action,
  output logic [rcgn_pkg::DEG_W-1:0]   degree_q8,
  output logic [rcgn_pkg::VEL_W-1:0]   velocity_q8,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [rcgn_pkg::TICK_W-1:0]  cfg_data
);
  import rcgn_pkg::*;

  logic  q_full;
  logic  push;
  work_t push_item;
  logic  pop;
  logic  q_valid;
  work_t q_item;

  // register writes always complete
  assign cfg_ready = 1'b1;

  rcgn_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .opcode       (opcode),
    .from_wheel   (from_wheel),
    .timestamp_us (timestamp_us),
    .scroll_v120  (scroll_v120),
    .cfg_valid    (cfg_valid),
    .cfg_data     (cfg_data),
    .q_full       (q_full),
    .push         (push),
    .push_item    (push_item)
  );

  rcgn_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_item    (q_item)
  );

  rcgn_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .action      (action),
    .degree_q8   (degree_q8),
    .velocity_q8 (velocity_q8)
  );

endmodule
